/* design/slotted_page_directory_macros.svh */
// Assertion macros shared by the slotted page directory modules.
`ifndef SLOTTED_PAGE_DIRECTORY_MACROS_SVH
`define SLOTTED_PAGE_DIRECTORY_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SPD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("slotted page directory check failed");

// Consequence that must hold in the cycle after the antecedent.
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slotted page directory check failed");

`endif

/* design/spd_pkg.sv */
// Types and constants shared by the slotted page directory modules.
package spd_pkg;

  localparam int PAGE_BYTES        = 4096;
  localparam int PAGE_HEADER_BYTES = 4;
  localparam int DIR_HEADER_BYTES  = 4;
  localparam int SLOT_ENTRY_BYTES  = 6;
  localparam int MAX_SLOTS_DEF     = 1024;

  localparam int KIND_W   = 3;
  localparam int IDX_W    = 10;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 88;

  // Signed gap from the free pointer to the directory end plus one entry.
  localparam int ROOM_W        = 18;
  localparam int FP_INIT_INT   = (PAGE_BYTES - PAGE_HEADER_BYTES) % 65536;
  localparam int ROOM_INIT_INT = FP_INIT_INT - (DIR_HEADER_BYTES + SLOT_ENTRY_BYTES);
  localparam int SPACE_INIT_INT = (ROOM_INIT_INT < 0) ? 0 : ROOM_INIT_INT;

  localparam logic [SIZE_W-1:0]        FP_INIT    = SIZE_W'(FP_INIT_INT);
  localparam logic signed [ROOM_W-1:0] ROOM_INIT  = ROOM_W'(ROOM_INIT_INT);
  localparam logic [SIZE_W-1:0]        SPACE_INIT = SIZE_W'(SPACE_INIT_INT);

  typedef enum logic [KIND_W-1:0] {
    KIND_FORMAT = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_UPDATE = 3'd3,
    KIND_LOOKUP = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_RANGE    = 2'd2,
    STATUS_DELETED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RELOC
  } state_e;

  typedef struct packed {
    logic              dead;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] size;
  } slot_entry_t;

  typedef struct packed {
    logic load;      // take the request word and read its directory entry
    logic exec;      // evaluate the request and commit its result
    logic reloc_wr;  // mark the old slot of a relocating update deleted
  } dp_cmd_t;

  typedef struct packed {
    logic out_blocked;  // result register full and not being taken
    logic reloc;        // pending request is an update that moves its tuple
  } dp_sts_t;

endpackage

/* design/slotted_page_directory.sv */
// Top level of the slotted page directory: controller plus datapath.
//
// Keeps the slot directory and free-space accounting of one page. The
// cycle that accepts a request word also reads the addressed directory
// entry from the slot memory; the EXEC state, held while the result register
// is full and not taken, then evaluates the request, writes the entry back
// and loads the result word. An update that moves its tuple adds a RELOC
// state, since the new entry and the deleted mark on the old one are two
// writes on the memory's single write port. The result sits in an output
// register, so the next request is accepted while the previous word waits;
// that request finishes once the word is taken. The directory memory needs
// no clearing after reset: only entries below the slot count are ever used.
module slotted_page_directory #(
  parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tdata: slot_index [9:0], tuple_len [25:10], zeros above
  input  logic [spd_pkg::S_TDATA_W-1:0] s_tdata,
  // tuser: kind [2:0]
  input  logic [spd_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tdata: status [1:0], result_slot [11:2], tuple_offset [27:12],
  // stored_size [43:28], slot_total [54:44], space_left [70:55],
  // live_tuples [81:71], zeros above
  output logic [spd_pkg::M_TDATA_W-1:0] m_tdata
);
  import spd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spd_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* design/spd_datapath.sv */
// Datapath: slot directory memory, page counters and the result register.
`include "slotted_page_directory_macros.svh"

module spd_datapath #(
  parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  spd_pkg::dp_cmd_t                cmd,
  output spd_pkg::dp_sts_t                sts,
  input  logic [spd_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [spd_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [spd_pkg::M_TDATA_W-1:0]   m_tdata
);
  import spd_pkg::*;

  localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  slot_entry_t mem [MAX_SLOTS];

  // Request registers.
  logic [KIND_W-1:0]        kind_q;
  logic [IDX_W-1:0]         idx_q;
  logic [SIZE_W-1:0]        size_q;
  logic signed [ROOM_W-1:0] need_q;
  slot_entry_t              rd_q;

  // Page state.
  logic [CW-1:0]            slot_used, slot_used_next;
  logic [CW-1:0]            live, live_next;
  logic [SIZE_W-1:0]        fp, fp_next;
  logic signed [ROOM_W-1:0] room, room_next;

  // Result register.
  logic                  out_valid;
  status_e               out_status, res_status;
  logic [IDX_W-1:0]      out_slot, res_slot;
  logic [SIZE_W-1:0]     out_off, res_off;
  logic [SIZE_W-1:0]     out_size, res_size;
  logic [COUNT_W-1:0]    out_total;
  logic [SIZE_W-1:0]     out_space, res_space;
  logic [COUNT_W-1:0]    out_live;

  logic signed [ROOM_W-1:0] diff;
  logic                     insert_ok;
  logic                     in_range;
  logic [SIZE_W-1:0]        new_off;
  logic [SIZE_W-1:0]        room_clamp;
  logic                     wr_req;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr, res_addr;
  slot_entry_t              wr_data, res_data;

  assign diff       = room - need_q;
  assign insert_ok  = !diff[ROOM_W-1] && (slot_used != CW'(MAX_SLOTS));
  assign in_range   = CMPW'(idx_q) < CMPW'(slot_used);
  assign new_off    = fp - size_q;
  assign room_clamp = room[ROOM_W-1] ? '0 : room[SIZE_W-1:0];

  assign sts.out_blocked = out_valid && !m_tready;
  assign sts.reloc = (kind_q == KIND_UPDATE) && in_range && !rd_q.dead &&
                     (size_q > rd_q.size) && insert_ok;

  always_comb begin
    slot_used_next = slot_used;
    live_next      = live;
    fp_next        = fp;
    room_next      = room;
    res_status     = STATUS_OK;
    res_slot       = idx_q;
    res_off        = '0;
    res_size       = '0;
    res_space      = room_clamp;
    wr_req         = 1'b0;
    res_addr       = AW'(idx_q);
    res_data       = rd_q;
    unique case (kind_q)
      KIND_FORMAT: begin
        slot_used_next = '0;
        live_next      = '0;
        fp_next        = FP_INIT;
        room_next      = ROOM_INIT;
        res_space      = SPACE_INIT;
      end
      KIND_INSERT, KIND_DELETE, KIND_UPDATE, KIND_LOOKUP: begin
        if (kind_q != KIND_INSERT && !in_range) begin
          res_status = STATUS_RANGE;
        end else if (kind_q != KIND_INSERT && rd_q.dead) begin
          res_status = STATUS_DELETED;
        end else if (kind_q == KIND_DELETE) begin
          live_next     = live - 1'b1;
          res_off       = rd_q.offset;
          res_size      = rd_q.size;
          wr_req        = 1'b1;
          res_data.dead = 1'b1;
        end else if (kind_q == KIND_LOOKUP) begin
          res_off  = rd_q.offset;
          res_size = rd_q.size;
        end else if (kind_q == KIND_UPDATE && size_q <= rd_q.size) begin
          res_off       = rd_q.offset;
          res_size      = size_q;
          wr_req        = 1'b1;
          res_data.size = size_q;
        end else if (insert_ok) begin
          // Plain insert, or the new copy of a growing update. The update
          // keeps the live count: the old slot dies as the new one appears.
          slot_used_next = slot_used + 1'b1;
          if (kind_q == KIND_INSERT) begin
            live_next = live + 1'b1;
          end
          fp_next   = new_off;
          room_next = diff;
          res_slot  = IDX_W'(slot_used);
          res_off   = new_off;
          res_size  = size_q;
          res_space = diff[SIZE_W-1:0];
          wr_req    = 1'b1;
          res_addr  = AW'(slot_used);
          res_data  = '{dead: 1'b0, offset: new_off, size: size_q};
        end else begin
          res_status = STATUS_NO_SPACE;
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_en   = (cmd.exec && wr_req) || cmd.reloc_wr;
  assign wr_addr = cmd.reloc_wr ? AW'(idx_q) : res_addr;
  always_comb begin
    wr_data = res_data;
    if (cmd.reloc_wr) begin
      wr_data      = rd_q;
      wr_data.dead = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= s_tuser;
      idx_q  <= s_tdata[IDX_W-1:0];
      size_q <= s_tdata[IDX_W+SIZE_W-1:IDX_W];
      need_q <= ROOM_W'(s_tdata[IDX_W+SIZE_W-1:IDX_W]) + ROOM_W'(SLOT_ENTRY_BYTES);
      rd_q   <= mem[AW'(s_tdata[IDX_W-1:0])];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      live      <= '0;
      fp        <= FP_INIT;
      room      <= ROOM_INIT;
    end else if (cmd.exec) begin
      slot_used <= slot_used_next;
      live      <= live_next;
      fp        <= fp_next;
      room      <= room_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_off    <= res_off;
      out_size   <= res_size;
      out_total  <= COUNT_W'(slot_used_next);
      out_space  <= res_space;
      out_live   <= COUNT_W'(live_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_live, out_space, out_total, out_size, out_off,
                     out_slot, out_status};

  `SPD_ASSERT_ALWAYS(a_live_within_used, live <= slot_used)
  `SPD_ASSERT_ALWAYS(a_used_within_max, slot_used <= CW'(MAX_SLOTS))
  `SPD_ASSERT_ALWAYS(a_room_tracks_pointer, room == (ROOM_W'(fp) - ROOM_W'(DIR_HEADER_BYTES) - ROOM_W'(slot_used + 1'b1) * ROOM_W'(SLOT_ENTRY_BYTES)))
  `SPD_ASSERT_NEXT(a_exec_shows_word, cmd.exec, m_tvalid)

endmodule

/* design/spd_ctrl.sv */
// Controller: sequences request intake, evaluation and the relocation write.
`include "slotted_page_directory_macros.svh"

module spd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  spd_pkg::dp_sts_t sts,
  output spd_pkg::dp_cmd_t cmd
);
  import spd_pkg::*;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Hold the request until the result register can take its word.
        if (!sts.out_blocked) begin
          cmd.exec   = 1'b1;
          state_next = sts.reloc ? ST_RELOC : ST_IDLE;
        end
      end
      ST_RELOC: begin
        cmd.reloc_wr = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SPD_ASSERT_NEXT(a_reloc_single_cycle, state == ST_RELOC, state == ST_IDLE)

endmodule
